// ===== hw/rtl/wms_pkg.sv =====
// Package for the weighted median selector.
// Holds the beat types, status codes and default sizes; no dependencies.
package wms_pkg;

    localparam int MAX_PAIRS_DEF = 64;
    localparam int VALUE_W       = 32;
    localparam int WEIGHT_W      = 32;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_WEIGHT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED     = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic [WEIGHT_W-1:0]       sample_weight;
        logic                      last_pair;
    } t_pair_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] median_value;
        logic [STATUS_W-1:0]       result_status;
    } t_result_out;

endpackage

// ===== hw/rtl/wms_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/weighted_median_select.sv =====
// Lower weighted median selector, top level.
// Depends on wms_pkg and wms_ram.
//
// Usage:
//   Pairs (value, weight) arrive as beats on the i_pair channel, one beat per
//   cycle while o_pair_ready is high. A beat with last_pair set closes the set.
//   Up to MAX_PAIRS pairs are kept; later ones are dropped and flagged.
//   After the closing beat o_pair_ready stays low while a single shared
//   compare/accumulate unit walks the pair store through its one read port:
//   for each candidate value it sums the weight of all pairs not above it.
//   Candidates not below the best one so far are skipped without a sum pass,
//   and a pending result not yet taken delays the new result until the old one leaves.
//   One result beat per set leaves on o_result from an output register: the
//   median and a status (ok, zero total weight, pairs dropped). A zero total
//   gives median 0. The result holds while i_result_ready is low; pairs of the
//   next set are taken meanwhile, and the sequencer holds at the end of that
//   set until the output register is free.
//   Reset clears the pair count, the running total, the output valid flag and
//   the sequencer; the store is not cleared, since only pairs of the current
//   set are ever read.
module weighted_median_select
    import wms_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pair_valid,
    output logic        o_pair_ready,
    input  t_pair_in    i_pair,
    output logic        o_result_valid,
    input  logic        i_result_ready,
    output t_result_out o_result
);

    localparam int AW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int TW = WEIGHT_W + AW;
    localparam int SW = VALUE_W + WEIGHT_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_START  = 6'b000010,
        ST_CAND   = 6'b000100,
        ST_SUM    = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [TW-1:0]              r_total, n_total;
    logic                       r_ovf, n_ovf;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_jdx, n_jdx;
    logic signed [VALUE_W-1:0]  r_cand, n_cand;
    logic [TW-1:0]              r_below, n_below;
    logic signed [VALUE_W-1:0]  r_best, n_best;
    logic                       r_found, n_found;
    logic [STATUS_W-1:0]        r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    t_result_out                r_out, n_out;

    logic                       w_pair_fire;
    logic                       w_result_fire;
    logic                       w_room;
    logic                       w_skip;
    logic [CW-1:0]              w_idx_inc;
    logic [CW-1:0]              w_jdx_inc;
    logic [AW-1:0]              w_raddr;
    logic [SW-1:0]              w_rdata;
    logic signed [VALUE_W-1:0]  w_rd_val;
    logic [WEIGHT_W-1:0]        w_rd_wt;

    assign o_pair_ready   = (r_state == ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign w_pair_fire    = i_pair_valid && o_pair_ready;
    assign w_result_fire  = r_out_valid && i_result_ready;
    assign w_room         = (r_count < CW'(MAX_PAIRS));
    assign w_idx_inc      = r_idx + CW'(1);
    assign w_jdx_inc      = r_jdx + CW'(1);
    assign w_rd_val       = w_rdata[SW-1 -: VALUE_W];
    assign w_rd_wt        = w_rdata[WEIGHT_W-1:0];
    assign w_skip         = r_found && (w_rd_val >= r_best);

    assign o_result = r_out;

    wms_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_PAIRS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_pair_fire && w_room),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_pair.sample_value, i_pair.sample_weight}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        case (r_state)
            ST_CAND:   w_raddr = w_skip ? w_idx_inc[AW-1:0] : '0;
            ST_SUM:    w_raddr = w_jdx_inc[AW-1:0];
            ST_DECIDE: w_raddr = w_idx_inc[AW-1:0];
            default:   w_raddr = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_jdx       = r_jdx;
        n_cand      = r_cand;
        n_below     = r_below;
        n_best      = r_best;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_result_fire) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_pair_fire) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                        n_total = r_total + TW'(i_pair.sample_weight);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_pair.last_pair) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_best  = '0;
                if (r_total == '0) begin
                    n_status = STATUS_ZERO_WEIGHT;
                    n_state  = ST_OUT;
                    n_count  = '0;
                    n_total  = '0;
                    n_ovf    = 1'b0;
                end else begin
                    n_state = ST_CAND;
                end
            end
            ST_CAND: begin
                n_cand = w_rd_val;
                if (w_skip) begin
                    n_idx = w_idx_inc;
                    if (w_idx_inc == r_count) begin
                        n_status = r_ovf ? STATUS_DROPPED : STATUS_OK;
                        n_state  = ST_OUT;
                        n_count  = '0;
                        n_total  = '0;
                        n_ovf    = 1'b0;
                    end
                end else begin
                    n_jdx   = '0;
                    n_below = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_rd_val <= r_cand) begin
                    n_below = r_below + TW'(w_rd_wt);
                end
                n_jdx = w_jdx_inc;
                if (w_jdx_inc == r_count) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ({r_below, 1'b0} >= {1'b0, r_total}) begin
                    n_best  = r_cand;
                    n_found = 1'b1;
                end
                n_idx = w_idx_inc;
                if (w_idx_inc == r_count) begin
                    n_status = r_ovf ? STATUS_DROPPED : STATUS_OK;
                    n_state  = ST_OUT;
                    n_count  = '0;
                    n_total  = '0;
                    n_ovf    = 1'b0;
                end else begin
                    n_state = ST_CAND;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_result_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.median_value    = r_best;
                    n_out.result_status   = r_status;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_jdx    <= n_jdx;
        r_cand   <= n_cand;
        r_below  <= n_below;
        r_best   <= n_best;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !i_result_ready) |=> (o_result_valid && $stable(o_result)))
        else $error("result beat dropped or changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAIRS))
        else $error("pair count beyond capacity");

    a_zero_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.result_status == STATUS_ZERO_WEIGHT)
            |-> o_result.median_value == '0)
        else $error("zero-weight result with nonzero median");

    a_found_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_status != STATUS_ZERO_WEIGHT) |-> r_found)
        else $error("result without a qualifying candidate");
`endif

endmodule
